/* rtl/lkbs_pkg.sv */
// Package for the link keepalive and backoff supervisor.
// Holds the shared constants, command codes, register indexes and interface structs.
// No dependencies.
package lkbs_pkg;

  // Width of the wrapping time base. The timestamp port stays 32 bits wide.
  localparam int TIME_BITS = 32;
  localparam int NOW_W     = 32;
  localparam int CMD_W     = 3;
  localparam int DELAY_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_ADDR_W = 2;

  // The pong timeout threshold is three heartbeat intervals.
  localparam int HB3_W     = CFG_W + 2;
  localparam int CMP_W     = (TIME_BITS > HB3_W) ? TIME_BITS : HB3_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_W-1:0] RETRY_MIN_RST = 16'd1;
  localparam logic [CFG_W-1:0] RETRY_MAX_RST = 16'd60;
  localparam logic [CFG_W-1:0] HEARTBEAT_RST = 16'd30;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 3'd0,
    CMD_OPEN        = 3'd1,
    CMD_ESTABLISHED = 3'd2,
    CMD_REFUSED     = 3'd3,
    CMD_ERROR       = 3'd4,
    CMD_PONG        = 3'd5,
    CMD_SHUTDOWN    = 3'd6
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RETRY_MIN = 2'd0,
    REG_RETRY_MAX = 2'd1,
    REG_HEARTBEAT = 2'd2
  } cfg_reg_t;

  // Current configuration plus a one-cycle pulse that reloads the retry delay.
  typedef struct packed {
    logic [CFG_W-1:0] retry_min;
    logic [CFG_W-1:0] retry_max;
    logic [CFG_W-1:0] heartbeat;
    logic             min_load;
  } cfg_t;

  // One result item. The last member sits in bit 0, so start_attempt is the lowest bit.
  typedef struct packed {
    logic [DELAY_W-1:0] delay_now_s;
    logic               is_connecting;
    logic               is_connected;
    logic               link_down;
    logic               link_up;
    logic               force_close;
    logic               send_ping;
    logic               start_attempt;
  } res_t;

endpackage

/* rtl/lkbs_cfg.sv */
// Configuration register bank of the link supervisor.
// Depends on lkbs_pkg.
module lkbs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [lkbs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lkbs_pkg::CFG_W-1:0]      cfg_wdata,
  output lkbs_pkg::cfg_t                 cfg
);
  import lkbs_pkg::*;

  logic [CFG_W-1:0] retry_min_r, retry_min_nxt;
  logic [CFG_W-1:0] retry_max_r, retry_max_nxt;
  logic [CFG_W-1:0] heartbeat_r, heartbeat_nxt;
  logic             min_load_r, min_load_nxt;

  always_comb begin
    retry_min_nxt = retry_min_r;
    retry_max_nxt = retry_max_r;
    heartbeat_nxt = heartbeat_r;
    min_load_nxt  = 1'b0;
    if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RETRY_MIN: begin
          retry_min_nxt = cfg_wdata;
          min_load_nxt  = 1'b1;
        end
        REG_RETRY_MAX: retry_max_nxt = cfg_wdata;
        REG_HEARTBEAT: heartbeat_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_min_r <= RETRY_MIN_RST;
      retry_max_r <= RETRY_MAX_RST;
      heartbeat_r <= HEARTBEAT_RST;
      min_load_r  <= 1'b0;
    end else begin
      retry_min_r <= retry_min_nxt;
      retry_max_r <= retry_max_nxt;
      heartbeat_r <= heartbeat_nxt;
      min_load_r  <= min_load_nxt;
    end
  end

  assign cfg.retry_min = retry_min_r;
  assign cfg.retry_max = retry_max_r;
  assign cfg.heartbeat = heartbeat_r;
  assign cfg.min_load  = min_load_r;

endmodule

/* rtl/lkbs_core.sv */
// Link state registers and the single-pass event logic of the supervisor.
// Depends on lkbs_pkg.
module lkbs_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [lkbs_pkg::CMD_W-1:0] cmd,
  input  logic [lkbs_pkg::NOW_W-1:0] now_s,
  input  lkbs_pkg::cfg_t            cfg,
  output lkbs_pkg::res_t            res
);
  import lkbs_pkg::*;

  logic                 connected_r, connected_nxt;
  logic                 connecting_r, connecting_nxt;
  logic                 shutdown_r, shutdown_nxt;
  logic [DELAY_W-1:0]   delay_r, delay_nxt, delay_step, delay_cur;
  logic [TIME_BITS-1:0] next_retry_r, next_retry_nxt;
  logic [TIME_BITS-1:0] last_ping_r, last_ping_nxt;
  logic [TIME_BITS-1:0] last_pong_r, last_pong_nxt;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] age_retry, age_ping, age_pong, retry_at;
  logic [HB3_W-1:0]     hb3;
  logic [DELAY_W:0]     doubled;
  logic [DELAY_W-1:0]   doubled_capped;
  logic                 hb_on, retry_due, ping_due, pong_late;

  // A write of the minimum delay takes effect at once, before the register catches up.
  assign delay_cur = cfg.min_load ? cfg.retry_min : delay_r;

  assign now_t     = TIME_BITS'(now_s);
  assign age_retry = now_t - next_retry_r;
  assign age_ping  = now_t - last_ping_r;
  assign age_pong  = now_t - last_pong_r;
  assign retry_at  = now_t + TIME_BITS'(delay_cur);
  assign hb3       = HB3_W'(cfg.heartbeat) + {1'b0, cfg.heartbeat, 1'b0};
  assign hb_on     = (cfg.heartbeat != '0);
  // Retry is due once now is at or past the scheduled time in wrapping arithmetic.
  assign retry_due = !age_retry[TIME_BITS-1];
  assign ping_due  = CMP_W'(age_ping) >= CMP_W'(cfg.heartbeat);
  assign pong_late = CMP_W'(age_pong) > CMP_W'(hb3);
  assign doubled   = {delay_cur, 1'b0};
  assign doubled_capped = (doubled > (DELAY_W+1)'(cfg.retry_max)) ? cfg.retry_max
                                                                   : doubled[DELAY_W-1:0];

  always_comb begin
    connected_nxt     = connected_r;
    connecting_nxt    = connecting_r;
    shutdown_nxt      = shutdown_r;
    delay_step        = delay_cur;
    next_retry_nxt    = next_retry_r;
    last_ping_nxt     = last_ping_r;
    last_pong_nxt     = last_pong_r;
    res.start_attempt = 1'b0;
    res.send_ping     = 1'b0;
    res.force_close   = 1'b0;
    res.link_up       = 1'b0;
    res.link_down     = 1'b0;
    if (!shutdown_r) begin
      unique case (cmd_t'(cmd))
        CMD_TICK: begin
          if (!connected_r && !connecting_r && retry_due) begin
            res.start_attempt = 1'b1;
            connecting_nxt    = 1'b1;
          end
          if (connected_r && hb_on) begin
            if (ping_due) begin
              res.send_ping = 1'b1;
              last_ping_nxt = now_t;
            end
            res.force_close = pong_late;
          end
        end
        CMD_OPEN: begin
          if (!connected_r && !connecting_r) begin
            res.start_attempt = 1'b1;
            connecting_nxt    = 1'b1;
          end
        end
        CMD_ESTABLISHED: begin
          res.link_up    = !connected_r;
          connected_nxt  = 1'b1;
          connecting_nxt = 1'b0;
          delay_step     = cfg.retry_min;
          last_pong_nxt  = now_t;
        end
        CMD_REFUSED: begin
          if (connecting_r) begin
            connecting_nxt = 1'b0;
            next_retry_nxt = retry_at;
          end
        end
        CMD_ERROR: begin
          res.link_down  = connected_r;
          connected_nxt  = 1'b0;
          connecting_nxt = 1'b0;
          next_retry_nxt = retry_at;
          delay_step     = doubled_capped;
        end
        CMD_PONG: last_pong_nxt = now_t;
        CMD_SHUTDOWN: begin
          res.link_down  = connected_r;
          connected_nxt  = 1'b0;
          connecting_nxt = 1'b0;
          shutdown_nxt   = 1'b1;
        end
        default: ;
      endcase
    end
    res.is_connected  = connected_nxt;
    res.is_connecting = connecting_nxt;
    res.delay_now_s   = delay_step;
  end

  // A processed request updates the current delay; otherwise a write of the minimum delay reloads it.
  always_comb begin
    delay_nxt = step ? delay_step : delay_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connected_r  <= 1'b0;
      connecting_r <= 1'b0;
      shutdown_r   <= 1'b0;
      delay_r      <= RETRY_MIN_RST;
      next_retry_r <= '0;
      last_ping_r  <= '0;
      last_pong_r  <= '0;
    end else begin
      delay_r <= delay_nxt;
      if (step) begin
        connected_r  <= connected_nxt;
        connecting_r <= connecting_nxt;
        shutdown_r   <= shutdown_nxt;
        next_retry_r <= next_retry_nxt;
        last_ping_r  <= last_ping_nxt;
        last_pong_r  <= last_pong_nxt;
      end
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(connected_r && connecting_r))
    else $error("link is connected and connecting at once");

  a_shutdown_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    shutdown_r |=> shutdown_r)
    else $error("shutdown flag cleared without reset");

  a_shutdown_idle: assert property (@(posedge clk) disable iff (!rst_n)
    shutdown_r |-> (!connected_r && !connecting_r))
    else $error("link flags set after shutdown");

  a_shutdown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    shutdown_r |-> (!res.start_attempt && !res.send_ping && !res.link_up))
    else $error("activity reported after shutdown");

endmodule

/* rtl/link_keepalive_backoff_supervisor_unit.sv */
// Top level of the link keepalive and backoff supervisor.
// Depends on lkbs_pkg, lkbs_cfg and lkbs_core.

// This block supervises one network link from a stream of timestamped events
// (tick, open, established, refused, error or close, pong, shutdown) and answers
// every request with exactly one result that says whether to start a connection
// attempt, send a heartbeat ping or force a close, plus the link flags and the
// current retry delay. It takes one request per clock cycle while results are being
// drained: a request is held in an input register, the event logic reads it and the
// link state in a single pass, and the result lands in an output register that
// drives out_tvalid. The throughput of one request per cycle is set by that
// single-pass step. The output register decouples the two sides: one more request
// is still taken while a finished result waits, after which in_tready stays low
// until the result is drained. Configuration writes are meant for idle periods
// only; writing retry_min_s also reloads the current retry delay, and every
// request processed after the write sees the new value.
module link_keepalive_backoff_supervisor_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input requests.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lkbs_pkg::IN_DATA_W-1:0]    in_tdata,   // cmd[2:0], now_s[34:3], unused
  // Results.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lkbs_pkg::OUT_DATA_W-1:0]   out_tdata,  // start_attempt, send_ping,
                                                        // force_close, link_up,
                                                        // link_down, is_connected,
                                                        // is_connecting,
                                                        // delay_now_s[22:7], zero
  // Configuration writes.
  input  logic                              cfg_wen,
  input  logic [lkbs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lkbs_pkg::CFG_W-1:0]        cfg_wdata
);
  import lkbs_pkg::*;

  localparam int PAD_W = OUT_DATA_W - $bits(res_t);

  logic             s1_valid_r, s1_valid_nxt;
  logic [CMD_W-1:0] s1_cmd_r;
  logic [NOW_W-1:0] s1_now_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;
  res_t             res;
  cfg_t             cfg;
  logic             advance, step, in_take;

  // The input stage moves on whenever the output register is empty or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= in_tdata[CMD_W-1:0];
      s1_now_r <= in_tdata[CMD_W+NOW_W-1:CMD_W];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  lkbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lkbs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cmd   (s1_cmd_r),
    .now_s (s1_now_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_res_r};

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result lost or changed");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_cmd_r) && $stable(s1_now_r)))
    else $error("held request dropped before processing");

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed request produced no result");

endmodule
